// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clock, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("assertion failed");

// when ante holds, cons must hold on the next clock
`define ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: hdl/sedc_pkg.sv
// ---------------------------------------------------------------------------
// sedc_pkg
// Types and constants of the Sobel edge direction classifier.
// ---------------------------------------------------------------------------
package sedc_pkg;

   localparam int PIX_W      = 8;
   localparam int LUMA_W     = 24;             // Q16 luma, 8 integer bits
   localparam int SUM_W      = LUMA_W + 2;     // 1,2,1 weighted column sum
   localparam int GRAD_W     = SUM_W + 1;      // signed gradient
   localparam int GCMP_W     = GRAD_W + 1;     // gradient vs. threshold compare
   localparam int FRAC_W     = 16;
   localparam int THR_W      = 10;
   localparam int SIZE_W     = 11;
   localparam int CODE_W     = 3;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 11;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 8;

   localparam logic [15:0] COEF_R = 16'd19595;
   localparam logic [15:0] COEF_G = 16'd38470;
   localparam logic [15:0] COEF_B = 16'd7471;

   localparam logic [THR_W-1:0]  THR_RESET  = 10'd100;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;
   localparam logic [SIZE_W-1:0] SIZE_MIN   = 11'd3;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_EDGE_THRESHOLD = 2'd0,
      REG_IMAGE_WIDTH    = 2'd1,
      REG_IMAGE_HEIGHT   = 2'd2
   } csr_index_type;

   typedef enum logic [CODE_W-1:0] {
      EDGE_UP         = 3'd0,
      EDGE_DOWN       = 3'd1,
      EDGE_LEFT       = 3'd2,
      EDGE_RIGHT      = 3'd3,
      EDGE_UP_LEFT    = 3'd4,
      EDGE_UP_RIGHT   = 3'd5,
      EDGE_DOWN_LEFT  = 3'd6,
      EDGE_DOWN_RIGHT = 3'd7
   } edge_code_type;

   typedef struct packed {
      logic center_valid;
      logic on_border;
   } pix_flags_type;

   localparam int FLAGS_W = $bits(pix_flags_type);

endpackage

// File: hdl/sobel_edge_direction_classifier.sv
// ---------------------------------------------------------------------------
// sobel_edge_direction_classifier
// Streaming RGB-to-luma Sobel 3x3 edge direction classifier.
// ---------------------------------------------------------------------------
// Takes one RGB pixel per clock in raster order and returns one result per
// pixel, sustained at one request per clock with no gaps while the output is
// not stalled. A result passes these registers after its request is accepted:
// luma products, queue slot, line store read, gradient register. The rate is
// set by the two line stores, each a single memory with one write and one
// registered read per clock; a same-column write/read on one clock is
// forwarded. A four-entry queue sits between the intake and the gradient back
// end, so a stalled output does not hold the input until the queue fills.
// Each result describes the centre one row and one column behind the
// incoming pixel: center_valid, the 3-bit direction code, over_threshold and
// on_border (border centres report code up and no threshold crossing).
// image_width and image_height are clamped to 3..MAX_WIDTH / MAX_HEIGHT.
// Configuration must be written only while the block is idle; the block does
// not enforce this. There is no store clearing pass after reset; stale line
// store data only feed results whose centre is invalid or on the border.
// ---------------------------------------------------------------------------
module sobel_edge_direction_classifier import sedc_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   // request: pixel in
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,    // red[7:0], green[15:8], blue[23:16]
   input  logic                  req_tuser,    // frame_start
   // response: classification out
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,    // center_valid[0], edge_code[3:1],
                                               // over_threshold[4], on_border[5], zero[7:6]
   // configuration write port
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int WB      = $clog2(MAX_WIDTH + 1);
   localparam int HB      = $clog2(MAX_HEIGHT + 1);
   localparam int SB      = (WB > HB) ? WB : HB;
   localparam int CMP_W   = (SB > SIZE_W) ? SB : SIZE_W;
   localparam int Q_W     = COL_W + LUMA_W + FLAGS_W;
   localparam int Q_DEPTH = 4;

   // configuration registers
   logic [THR_W-1:0]  thr_ff, thr_in;
   logic [SIZE_W-1:0] width_ff, width_in;
   logic [SIZE_W-1:0] height_ff, height_in;

   always_comb begin
      thr_in    = thr_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_EDGE_THRESHOLD: thr_in    = csr_wdata[THR_W-1:0];
            REG_IMAGE_WIDTH:    width_in  = csr_wdata[SIZE_W-1:0];
            REG_IMAGE_HEIGHT:   height_in = csr_wdata[SIZE_W-1:0];
            default: ;                     // unmapped index: ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= THR_RESET;
         width_ff  <= SIZE_RESET;
         height_ff <= SIZE_RESET;
      end else begin
         thr_ff    <= thr_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // clamped frame size
   logic [CMP_W-1:0] width_ext, height_ext, width_lim, height_lim;

   always_comb begin
      width_ext  = CMP_W'(width_ff);
      height_ext = CMP_W'(height_ff);
      if (width_ext < CMP_W'(SIZE_MIN)) begin
         width_lim = CMP_W'(SIZE_MIN);
      end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
         width_lim = CMP_W'(MAX_WIDTH);
      end else begin
         width_lim = width_ext;
      end
      if (height_ext < CMP_W'(SIZE_MIN)) begin
         height_lim = CMP_W'(SIZE_MIN);
      end else if (height_ext > CMP_W'(MAX_HEIGHT)) begin
         height_lim = CMP_W'(MAX_HEIGHT);
      end else begin
         height_lim = height_ext;
      end
   end

   // intake: counters, flags, luma
   logic              push_valid, push_ready;
   logic [COL_W-1:0]  push_col, pop_col;
   logic [LUMA_W-1:0] push_luma, pop_luma;
   pix_flags_type     push_flags, pop_flags;
   logic [Q_W-1:0]    pop_data;
   logic              pop_valid, pop_ready;

   sedc_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .CMP_W      (CMP_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .red         (req_tdata[7:0]),
      .green       (req_tdata[15:8]),
      .blue        (req_tdata[23:16]),
      .frame_start (req_tuser),
      .width_lim   (width_lim),
      .height_lim  (height_lim),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_col    (push_col),
      .push_luma   (push_luma),
      .push_flags  (push_flags)
   );

   // decoupling queue
   sedc_queue #(
      .DATA_W (Q_W),
      .DEPTH  (Q_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_col, push_luma, push_flags}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   assign {pop_col, pop_luma, pop_flags} = pop_data;

   // back end: line stores, window, gradients, classification
   logic          center_valid, over_threshold, on_border;
   edge_code_type edge_code;

   sedc_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_col        (pop_col),
      .pop_luma       (pop_luma),
      .pop_flags      (pop_flags),
      .edge_threshold (thr_ff),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .center_valid   (center_valid),
      .edge_code      (edge_code),
      .over_threshold (over_threshold),
      .on_border      (on_border)
   );

   assign rsp_tdata = {2'b00, on_border, over_threshold, edge_code, center_valid};

endmodule

// File: hdl/sedc_front.sv
// ---------------------------------------------------------------------------
// sedc_front
// Pixel intake: raster counters, centre/border flags and Q16 luma.
// ---------------------------------------------------------------------------
module sedc_front import sedc_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int CMP_W      = 13
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [PIX_W-1:0]              red,
   input  logic [PIX_W-1:0]              green,
   input  logic [PIX_W-1:0]              blue,
   input  logic                          frame_start,
   input  logic [CMP_W-1:0]              width_lim,
   input  logic [CMP_W-1:0]              height_lim,
   output logic                          push_valid,
   input  logic                          push_ready,
   output logic [$clog2(MAX_WIDTH)-1:0]  push_col,
   output logic [LUMA_W-1:0]             push_luma,
   output pix_flags_type                 push_flags
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);

   logic [COL_W-1:0]  col_ff, col_in, col_cur;
   logic [ROW_W-1:0]  row_ff, row_in, row_cur;
   logic [CMP_W-1:0]  col_nxt, row_nxt;
   logic              accept;
   pix_flags_type     flags_cur;

   logic              f1_valid_ff, f1_valid_in;
   logic [COL_W-1:0]  f1_col_ff;
   pix_flags_type     f1_flags_ff;
   logic [LUMA_W-1:0] prod_r_ff, prod_g_ff, prod_b_ff;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !f1_valid_ff || push_ready;

   always_comb begin
      col_cur = frame_start ? '0 : col_ff;
      row_cur = frame_start ? '0 : row_ff;

      flags_cur.center_valid = (row_cur != '0) && (col_cur != '0);
      flags_cur.on_border    = flags_cur.center_valid &&
                               ((row_cur == ROW_W'(1)) || (col_cur == COL_W'(1)) ||
                                (CMP_W'(col_cur) >= width_lim) ||
                                (CMP_W'(row_cur) >= height_lim));

      // column wraps at line end, row at frame end; a lowered size wraps too
      col_nxt = CMP_W'(col_cur) + CMP_W'(1);
      row_nxt = CMP_W'(row_cur) + CMP_W'(1);
      col_in  = col_ff;
      row_in  = row_ff;
      if (accept) begin
         row_in = row_cur;
         if (col_nxt >= width_lim) begin
            col_in = '0;
            row_in = (row_nxt >= height_lim) ? '0 : row_nxt[ROW_W-1:0];
         end else begin
            col_in = col_nxt[COL_W-1:0];
         end
      end
   end

   always_comb begin
      f1_valid_in = f1_valid_ff;
      if (accept) begin
         f1_valid_in = 1'b1;
      end else if (push_ready) begin
         f1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         f1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         f1_valid_ff <= f1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f1_col_ff   <= col_cur;
         f1_flags_ff <= flags_cur;
         prod_r_ff   <= LUMA_W'(red)   * LUMA_W'(COEF_R);
         prod_g_ff   <= LUMA_W'(green) * LUMA_W'(COEF_G);
         prod_b_ff   <= LUMA_W'(blue)  * LUMA_W'(COEF_B);
      end
   end

   // coefficients sum to 65536, so the sum of products stays within 24 bits
   assign push_valid = f1_valid_ff;
   assign push_col   = f1_col_ff;
   assign push_flags = f1_flags_ff;
   assign push_luma  = prod_r_ff + prod_g_ff + prod_b_ff;

endmodule

// File: hdl/sedc_queue.sv
// ---------------------------------------------------------------------------
// sedc_queue
// Small FIFO between the pixel intake and the window/gradient back end.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sedc_queue import sedc_pkg::*; #(
   parameter int DATA_W = 36,
   parameter int DEPTH  = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [DATA_W-1:0] push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [DATA_W-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(DEPTH))
   `ASSERT_NEXT(a_count_up, push && !pop, count_ff == $past(count_ff) + CNT_W'(1))

endmodule

// File: hdl/sedc_back.sv
// ---------------------------------------------------------------------------
// sedc_back
// Line stores, 3x3 window, Sobel gradients and direction classification.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sedc_back import sedc_pkg::*; #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pop_valid,
   output logic                          pop_ready,
   input  logic [$clog2(MAX_WIDTH)-1:0]  pop_col,
   input  logic [LUMA_W-1:0]             pop_luma,
   input  pix_flags_type                 pop_flags,
   input  logic [THR_W-1:0]              edge_threshold,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic                          center_valid,
   output edge_code_type                 edge_code,
   output logic                          over_threshold,
   output logic                          on_border
);

   localparam int COL_W = $clog2(MAX_WIDTH);

   logic [LUMA_W-1:0] store_a_ff [MAX_WIDTH];   // previous line
   logic [LUMA_W-1:0] store_b_ff [MAX_WIDTH];   // line before that

   logic              s2_load, s2_adv, s3_adv;
   logic              s2_valid_ff, s2_valid_in;
   logic [COL_W-1:0]  s2_col_ff;
   logic [LUMA_W-1:0] s2_luma_ff;
   pix_flags_type     s2_flags_ff;
   logic [LUMA_W-1:0] rd_top_ff, rd_mid_ff;
   logic              fwd_ff, fwd_in;
   logic [LUMA_W-1:0] fwd_top_ff, fwd_mid_ff;
   logic [LUMA_W-1:0] s2_top, s2_mid;

   // window columns: c1 is one column back, c2 two columns back
   logic [LUMA_W-1:0] c1_top_ff, c1_mid_ff, c1_bot_ff;
   logic [LUMA_W-1:0] c2_top_ff, c2_mid_ff, c2_bot_ff;

   logic [SUM_W-1:0]         sum_r, sum_l, sum_b, sum_t;
   logic signed [GRAD_W-1:0] gx, gy;

   logic                     s3_valid_ff, s3_valid_in;
   logic signed [GRAD_W-1:0] s3_gx_ff, s3_gy_ff;
   pix_flags_type            s3_flags_ff;

   logic signed [GCMP_W-1:0] thr, gx_e, gy_e;
   logic                     up, down, left, right;

   assign s3_adv    = s3_valid_ff && rsp_tready;
   assign s2_adv    = s2_valid_ff && (!s3_valid_ff || s3_adv);
   assign pop_ready = !s2_valid_ff || s2_adv;
   assign s2_load   = pop_valid && pop_ready;

   // read and write of the same column on one edge: take the outgoing data
   assign fwd_in = s2_adv && (s2_col_ff == pop_col);
   assign s2_top = fwd_ff ? fwd_top_ff : rd_top_ff;
   assign s2_mid = fwd_ff ? fwd_mid_ff : rd_mid_ff;

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (s2_load) begin
         s2_valid_in = 1'b1;
      end else if (s2_adv) begin
         s2_valid_in = 1'b0;
      end
      s3_valid_in = s3_valid_ff;
      if (s2_adv) begin
         s3_valid_in = 1'b1;
      end else if (s3_adv) begin
         s3_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         store_b_ff[s2_col_ff] <= s2_mid;
         store_a_ff[s2_col_ff] <= s2_luma_ff;
      end
      if (s2_load) begin
         rd_top_ff <= store_b_ff[pop_col];
         rd_mid_ff <= store_a_ff[pop_col];
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_col_ff   <= pop_col;
         s2_luma_ff  <= pop_luma;
         s2_flags_ff <= pop_flags;
         fwd_ff      <= fwd_in;
         fwd_top_ff  <= s2_mid;
         fwd_mid_ff  <= s2_luma_ff;
      end
   end

   // gradients: s2_top/s2_mid/s2_luma are the right column
   always_comb begin
      sum_r = SUM_W'(s2_top) + SUM_W'({s2_mid, 1'b0}) + SUM_W'(s2_luma_ff);
      sum_l = SUM_W'(c2_top_ff) + SUM_W'({c2_mid_ff, 1'b0}) + SUM_W'(c2_bot_ff);
      sum_b = SUM_W'(c2_bot_ff) + SUM_W'({c1_bot_ff, 1'b0}) + SUM_W'(s2_luma_ff);
      sum_t = SUM_W'(c2_top_ff) + SUM_W'({c1_top_ff, 1'b0}) + SUM_W'(s2_top);
      gx    = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
      gy    = $signed({1'b0, sum_b}) - $signed({1'b0, sum_t});
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         c2_top_ff   <= c1_top_ff;
         c2_mid_ff   <= c1_mid_ff;
         c2_bot_ff   <= c1_bot_ff;
         c1_top_ff   <= s2_top;
         c1_mid_ff   <= s2_mid;
         c1_bot_ff   <= s2_luma_ff;
         s3_gx_ff    <= gx;
         s3_gy_ff    <= gy;
         s3_flags_ff <= s2_flags_ff;
      end
   end

   // later matches override earlier ones
   always_comb begin
      thr   = $signed(GCMP_W'({edge_threshold, FRAC_W'(0)}));
      gx_e  = GCMP_W'(s3_gx_ff);
      gy_e  = GCMP_W'(s3_gy_ff);
      up    = gy_e <= -thr;
      down  = gy_e >= thr;
      left  = gx_e <= -thr;
      right = gx_e >= thr;

      edge_code = EDGE_UP;
      if (down)           edge_code = EDGE_DOWN;
      if (left)           edge_code = EDGE_LEFT;
      if (right)          edge_code = EDGE_RIGHT;
      if (up && left)     edge_code = EDGE_UP_LEFT;
      if (up && right)    edge_code = EDGE_UP_RIGHT;
      if (down && left)   edge_code = EDGE_DOWN_LEFT;
      if (down && right)  edge_code = EDGE_DOWN_RIGHT;
      over_threshold = up || down || left || right;

      if (!s3_flags_ff.center_valid || s3_flags_ff.on_border) begin
         edge_code      = EDGE_UP;
         over_threshold = 1'b0;
      end
   end

   assign rsp_tvalid   = s3_valid_ff;
   assign center_valid = s3_flags_ff.center_valid;
   assign on_border    = s3_flags_ff.on_border;

   `ASSERT_ALWAYS(a_border_has_center, !(s3_valid_ff && on_border) || center_valid)
   `ASSERT_NEXT(a_fwd_loads_s2, s2_load && fwd_in, s2_valid_ff && fwd_ff)

endmodule
